// File: rtl/core/rrt_pkg.sv
// Shared types, widths and constants of the reachable-range tracker.
package rrt_pkg;

  // Fixed field widths.
  localparam int unsigned POS_W   = 32;
  localparam int unsigned STEP_W  = 24;
  localparam int unsigned LIM_W   = 31;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IX_W = 3;

  // Magnitude of a position difference or a speed sum before scaling.
  localparam int unsigned MAG_W   = 33;

  // Operand widths of the shared multiplier.
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 2 * STEP_W;

  // Every motion term is capped at 2^40.
  localparam int unsigned TERM_W  = 41;

  // Window accumulator: position plus three capped terms.
  localparam int unsigned ACC_W   = 44;

  localparam int unsigned FRAC_BITS_DEF = 16;

  // Register reset values.
  localparam logic signed [POS_W-1:0] POS_LOW_RST  = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_HIGH_RST = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [STEP_W-1:0]       STEP_RST     = STEP_W'(65536);
  localparam logic [LIM_W-1:0]        VEL_RST      = LIM_W'(65536);
  localparam logic [LIM_W-1:0]        ACC_RST      = LIM_W'(65536);

  // Configuration register indexes.
  typedef enum logic [CFG_IX_W-1:0] {
    CFG_POS_LOW   = 3'd0,
    CFG_POS_HIGH  = 3'd1,
    CFG_STEP_TIME = 3'd2,
    CFG_VEL_LIMIT = 3'd3,
    CFG_ACC_LIMIT = 3'd4
  } cfg_idx_e;

  // Stream payloads.
  typedef struct packed {
    logic signed [POS_W-1:0] proposed_position;
  } rrt_in_t;

  typedef struct packed {
    logic                    accepted;
    logic signed [POS_W-1:0] window_low;
    logic signed [POS_W-1:0] window_high;
    logic signed [POS_W-1:0] current_position;
  } rrt_out_t;

  // Requests to the shared units.
  typedef struct packed {
    logic [MAG_W-1:0] dividend;
    logic [LIM_W-1:0] divisor;
  } rrt_div_req_t;

  typedef struct packed {
    logic               wide;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } rrt_mul_req_t;

endpackage

// File: rtl/core/rrt_stream_if.sv
// Valid/ready stream channel carrying one payload word.
interface rrt_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/rrt_div.sv
// Restoring divider, one quotient bit per cycle, dividend scaled by 2^FRAC_BITS.
module rrt_div
  import rrt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  rrt_div_req_t                  req_i,
  output logic                          done_o,
  output logic [MAG_W+FRAC_BITS-1:0]    quot_o
);

  localparam int unsigned DW = MAG_W + FRAC_BITS;
  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0]    dq_q;
  logic [LIM_W-1:0] rem_q;
  logic [LIM_W-1:0] div_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [LIM_W:0]   trial;
  logic [LIM_W:0]   diff;
  logic             ge;

  // One trial subtraction per cycle.
  assign trial = {rem_q, dq_q[DW-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend bits shift out at the top, quotient bits in at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= {req_i.dividend, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      dq_q  <= {dq_q[DW-2:0], ge};
      rem_q <= ge ? diff[LIM_W-1:0] : trial[LIM_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

// File: rtl/core/rrt_mul.sv
// Shared multiplier: 32 x 48 bits as two registered 32 x 24 partial products.
module rrt_mul
  import rrt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  rrt_mul_req_t       req_i,
  output logic               done_o,
  output logic [MUL_B_W-1:0] prod_o,
  output logic [TERM_W-1:0]  term_o
);

  localparam int unsigned HALF   = MUL_B_W / 2;
  localparam int unsigned PP_W   = MUL_A_W + HALF;
  localparam int unsigned PROD_W = MUL_A_W + MUL_B_W;
  localparam int unsigned SH_N   = FRAC_BITS;
  localparam int unsigned SH_W   = 2 * FRAC_BITS + 1;
  localparam logic [PROD_W-1:0] CAP = PROD_W'(1) << (TERM_W - 1);

  typedef enum logic [1:0] {
    MP_IDLE,
    MP_LO,
    MP_HI,
    MP_ADD
  } phase_e;

  phase_e             phase_q;
  logic               done_q;
  logic               wide_q;
  logic [MUL_A_W-1:0] a_q;
  logic [MUL_B_W-1:0] b_q;
  logic [PP_W-1:0]    pp_q;
  logic [PROD_W-1:0]  acc_q;
  logic [PROD_W-1:0]  shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= MP_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (phase_q)
        MP_IDLE: if (start_i) phase_q <= MP_LO;
        MP_LO:   phase_q <= MP_HI;
        MP_HI:   phase_q <= MP_ADD;
        MP_ADD: begin
          phase_q <= MP_IDLE;
          done_q  <= 1'b1;
        end
        default: phase_q <= MP_IDLE;
      endcase
    end
  end

  // Low half product, then high half product while the low one is banked.
  always_ff @(posedge clk_i) begin
    if (start_i && phase_q == MP_IDLE) begin
      a_q    <= req_i.a;
      b_q    <= req_i.b;
      wide_q <= req_i.wide;
    end
    if (phase_q == MP_LO) begin
      pp_q <= a_q * b_q[HALF-1:0];
    end else if (phase_q == MP_HI) begin
      acc_q <= PROD_W'(pp_q);
      pp_q  <= a_q * b_q[MUL_B_W-1:HALF];
    end else if (phase_q == MP_ADD) begin
      acc_q <= acc_q + (PROD_W'(pp_q) << HALF);
    end
  end

  // Scaled and capped term.
  assign shifted = wide_q ? (acc_q >> SH_W) : (acc_q >> SH_N);
  assign term_o  = (shifted > CAP) ? CAP[TERM_W-1:0] : shifted[TERM_W-1:0];
  assign prod_o  = acc_q[MUL_B_W-1:0];
  assign done_o  = done_q;

endmodule

// File: rtl/core/axis_reachable_range_tracker.sv
// Top level of the axis reachable-range tracker with its step sequencer.
//
//  Channel | Dir | Word                                                     | Handshake
//  in_if   | in  | proposed_position                                        | valid/ready
//  out_if  | out | accepted, window_low, window_high, current_position      | valid/ready
//  cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i                          | write only
//
// One word at a time. A word that leaves no stored sample offers its result in the
// cycle after acceptance. With one sample the velocity is taken as zero and the
// sequencer runs the bit-serial divider for the two acceleration times; with two
// samples it runs the divider for the velocity and the two acceleration times.
// Eight multiplier passes and the final clamp follow before the result is offered.
// Reset clears the sample state and loads the register defaults; no clearing pass.
// The input is not ready from acceptance until the result word has been taken.
module axis_reachable_range_tracker
  import rrt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_IX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  rrt_stream_if.sink          in_if,
  rrt_stream_if.source        out_if
);

  localparam int unsigned QW = MAG_W + FRAC_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VEL_GO,
    ST_VEL_WAIT,
    ST_T1_GO,
    ST_T1_WAIT,
    ST_T2_GO,
    ST_T2_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_FIN,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    MS_UP_SQ,
    MS_UP_ACC,
    MS_UP_VEL,
    MS_UP_CRUISE,
    MS_LO_SQ,
    MS_LO_ACC,
    MS_LO_VEL,
    MS_LO_CRUISE
  } mul_step_e;

  // Configuration registers.
  logic signed [POS_W-1:0] pos_low_q, pos_high_q;
  logic [STEP_W-1:0]       step_q;
  logic [LIM_W-1:0]        vel_lim_q, acc_lim_q;

  // Sample state.
  logic signed [POS_W-1:0] latest_q, prev_q;
  logic [1:0]              count_q;

  // Sequencer state and working registers.
  state_e                  state_q;
  mul_step_e               step_k_q;
  logic                    ok_q;
  logic signed [POS_W-1:0] cur_q;
  logic                    v_neg_q;
  logic [LIM_W-1:0]        v_mag_q;
  logic [STEP_W-1:0]       tu_q, tl_q;
  logic [MUL_B_W-1:0]      sq_q;
  logic signed [ACC_W-1:0] hi_acc_q, lo_acc_q;
  logic signed [POS_W-1:0] wlo_q, whi_q;

  // Effective step time and acceleration: zero reads as one.
  logic [STEP_W-1:0] step_eff;
  logic [LIM_W-1:0]  acc_eff;
  assign step_eff = (step_q == '0) ? STEP_W'(1) : step_q;
  assign acc_eff  = (acc_lim_q == '0) ? LIM_W'(1) : acc_lim_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_low_q  <= POS_LOW_RST;
      pos_high_q <= POS_HIGH_RST;
      step_q     <= STEP_RST;
      vel_lim_q  <= VEL_RST;
      acc_lim_q  <= ACC_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_POS_LOW:   pos_low_q  <= cfg_data_i[POS_W-1:0];
        CFG_POS_HIGH:  pos_high_q <= cfg_data_i[POS_W-1:0];
        CFG_STEP_TIME: step_q     <= cfg_data_i[STEP_W-1:0];
        CFG_VEL_LIMIT: vel_lim_q  <= cfg_data_i[LIM_W-1:0];
        CFG_ACC_LIMIT: acc_lim_q  <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Acceptance decision and the state it leads to.
  logic                    in_acc, out_acc, ok;
  logic signed [POS_W-1:0] p;
  logic [1:0]              count_d;
  logic signed [POS_W:0]   bound_sum;
  logic signed [POS_W-1:0] cur_d;

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_acc     = out_if.valid && out_if.ready;
  assign p           = in_if.payload.proposed_position;
  assign ok          = (p >= pos_low_q) && (p <= pos_high_q);
  assign count_d     = (ok && count_q != 2'd2) ? count_q + 2'd1 : count_q;
  assign bound_sum   = {pos_low_q[POS_W-1], pos_low_q} + {pos_high_q[POS_W-1], pos_high_q};
  assign cur_d       = (count_d == 2'd0) ? bound_sum[POS_W:1] : (ok ? p : latest_q);

  // Velocity from the last difference.
  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0]        diff_mag;
  assign diff     = {latest_q[POS_W-1], latest_q} - {prev_q[POS_W-1], prev_q};
  assign diff_mag = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

  // Speed headroom toward the upper and lower limit.
  logic [MAG_W-1:0] vm_minus_v, vm_plus_v;
  assign vm_minus_v = v_neg_q ? MAG_W'(vel_lim_q) + MAG_W'(v_mag_q)
                              : MAG_W'(vel_lim_q) - MAG_W'(v_mag_q);
  assign vm_plus_v  = v_neg_q ? MAG_W'(vel_lim_q) - MAG_W'(v_mag_q)
                              : MAG_W'(vel_lim_q) + MAG_W'(v_mag_q);

  // Shared divider.
  rrt_div_req_t     div_req;
  logic             div_start, div_done;
  logic [QW-1:0]    quot;
  logic [STEP_W-1:0] quot_t;

  assign div_start = (state_q == ST_VEL_GO && count_q == 2'd2)
                  || state_q == ST_T1_GO || state_q == ST_T2_GO;
  assign quot_t    = (quot > QW'(step_eff)) ? step_eff : quot[STEP_W-1:0];

  always_comb begin
    div_req.dividend = diff_mag;
    div_req.divisor  = LIM_W'(step_eff);
    if (state_q == ST_T1_GO) begin
      div_req.dividend = vm_minus_v;
      div_req.divisor  = acc_eff;
    end else if (state_q == ST_T2_GO) begin
      div_req.dividend = vm_plus_v;
      div_req.divisor  = acc_eff;
    end
  end

  rrt_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Shared multiplier.
  rrt_mul_req_t       mul_req;
  logic               mul_start, mul_done;
  logic [MUL_B_W-1:0] prod;
  logic [TERM_W-1:0]  term;
  logic signed [ACC_W-1:0] term_ext;

  assign mul_start = (state_q == ST_MUL_GO);
  assign term_ext  = {{(ACC_W-TERM_W){1'b0}}, term};

  always_comb begin
    mul_req.wide = 1'b0;
    mul_req.a    = '0;
    mul_req.b    = '0;
    case (step_k_q)
      MS_UP_SQ: begin
        mul_req.a = MUL_A_W'(tu_q);
        mul_req.b = MUL_B_W'(tu_q);
      end
      MS_UP_ACC, MS_LO_ACC: begin
        mul_req.wide = 1'b1;
        mul_req.a    = MUL_A_W'(acc_eff);
        mul_req.b    = sq_q;
      end
      MS_UP_VEL: begin
        mul_req.a = MUL_A_W'(v_mag_q);
        mul_req.b = MUL_B_W'(tu_q);
      end
      MS_UP_CRUISE: begin
        mul_req.a = MUL_A_W'(vel_lim_q);
        mul_req.b = MUL_B_W'(step_eff - tu_q);
      end
      MS_LO_SQ: begin
        mul_req.a = MUL_A_W'(tl_q);
        mul_req.b = MUL_B_W'(tl_q);
      end
      MS_LO_VEL: begin
        mul_req.a = MUL_A_W'(v_mag_q);
        mul_req.b = MUL_B_W'(tl_q);
      end
      MS_LO_CRUISE: begin
        mul_req.a = MUL_A_W'(vel_lim_q);
        mul_req.b = MUL_B_W'(step_eff - tl_q);
      end
      default: ;
    endcase
  end

  rrt_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .req_i   (mul_req),
    .done_o  (mul_done),
    .prod_o  (prod),
    .term_o  (term)
  );

  // Final clamp to the bounds and to the 32 bit range.
  logic signed [ACC_W-1:0] pl_ext, ph_ext, lo_cl, hi_cl;
  localparam logic signed [ACC_W-1:0] POS_MAX = ACC_W'(POS_HIGH_RST);
  localparam logic signed [ACC_W-1:0] POS_MIN = ACC_W'(POS_LOW_RST);
  logic signed [POS_W-1:0] wlo_d, whi_d;

  assign pl_ext = ACC_W'(pos_low_q);
  assign ph_ext = ACC_W'(pos_high_q);
  assign lo_cl  = (lo_acc_q > pl_ext) ? lo_acc_q : pl_ext;
  assign hi_cl  = (hi_acc_q < ph_ext) ? hi_acc_q : ph_ext;
  assign wlo_d  = (lo_cl > POS_MAX) ? POS_HIGH_RST : POS_W'(lo_cl);
  assign whi_d  = (hi_cl < POS_MIN) ? POS_LOW_RST : POS_W'(hi_cl);

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_k_q <= MS_UP_SQ;
      count_q  <= 2'd0;
      latest_q <= '0;
      prev_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            ok_q     <= ok;
            count_q  <= count_d;
            cur_q    <= cur_d;
            hi_acc_q <= ACC_W'(cur_d);
            lo_acc_q <= ACC_W'(cur_d);
            if (ok) begin
              prev_q   <= latest_q;
              latest_q <= p;
            end
            if (count_d == 2'd0) begin
              wlo_q   <= pos_low_q;
              whi_q   <= pos_high_q;
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_VEL_GO;
            end
          end
        end
        ST_VEL_GO: begin
          v_neg_q <= (count_q == 2'd2) && diff[MAG_W-1];
          if (count_q == 2'd2) begin
            state_q <= ST_VEL_WAIT;
          end else begin
            v_mag_q <= '0;
            state_q <= ST_T1_GO;
          end
        end
        ST_VEL_WAIT: begin
          if (div_done) begin
            v_mag_q <= (quot > QW'(vel_lim_q)) ? vel_lim_q : quot[LIM_W-1:0];
            state_q <= ST_T1_GO;
          end
        end
        ST_T1_GO: state_q <= ST_T1_WAIT;
        ST_T1_WAIT: begin
          if (div_done) begin
            tu_q    <= quot_t;
            state_q <= ST_T2_GO;
          end
        end
        ST_T2_GO: state_q <= ST_T2_WAIT;
        ST_T2_WAIT: begin
          if (div_done) begin
            tl_q     <= quot_t;
            step_k_q <= MS_UP_SQ;
            state_q  <= ST_MUL_GO;
          end
        end
        ST_MUL_GO: state_q <= ST_MUL_WAIT;
        ST_MUL_WAIT: begin
          if (mul_done) begin
            case (step_k_q)
              MS_UP_SQ, MS_LO_SQ:  sq_q     <= prod;
              MS_UP_ACC:           hi_acc_q <= hi_acc_q + term_ext;
              MS_UP_CRUISE:        hi_acc_q <= hi_acc_q + term_ext;
              MS_UP_VEL:           hi_acc_q <= v_neg_q ? hi_acc_q - term_ext
                                                       : hi_acc_q + term_ext;
              MS_LO_ACC:           lo_acc_q <= lo_acc_q - term_ext;
              MS_LO_CRUISE:        lo_acc_q <= lo_acc_q - term_ext;
              MS_LO_VEL:           lo_acc_q <= v_neg_q ? lo_acc_q - term_ext
                                                       : lo_acc_q + term_ext;
              default: ;
            endcase
            if (step_k_q == MS_LO_CRUISE) begin
              state_q <= ST_FIN;
            end else begin
              step_k_q <= mul_step_e'(step_k_q + 3'd1);
              state_q  <= ST_MUL_GO;
            end
          end
        end
        ST_FIN: begin
          wlo_q   <= wlo_d;
          whi_q   <= whi_d;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_acc) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Result word.
  assign out_if.valid                    = (state_q == ST_OUT);
  assign out_if.payload.accepted         = ok_q;
  assign out_if.payload.window_low       = wlo_q;
  assign out_if.payload.window_high      = whi_q;
  assign out_if.payload.current_position = cur_q;

endmodule

// File: rtl/core/rrt_checker.sv
// Port-level checks of the tracker and their binding to the top level.
module rrt_checker
  import rrt_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input rrt_out_t out_payload_i
);

  // The block never takes a word while a result word is pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while a result word is pending");

  // Taking a word closes the input until the result is delivered.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input still ready after a word was accepted");

  // Delivering the result reopens the input.
  a_ready_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i) |=> (in_ready_i && !out_valid_i))
    else $error("input not reopened after the result word");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_payload_i)))
    else $error("stalled result word changed");

endmodule

bind axis_reachable_range_tracker rrt_checker u_rrt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .out_payload_i (out_if.payload)
);
